@@ design/cpfe_pkg.sv @@
`timescale 1ns / 1ps
// cpfe_pkg: shared widths, register indexes, command/status structs and the
// timebase scale table of the crossing period frequency estimator. No dependencies.
package cpfe_pkg;

  localparam int SampleW  = 8;
  localparam int PosW     = 10;  // stream and window positions
  localparam int CountW   = 4;
  localparam int PeriodW  = 9;   // period field as delivered
  localparam int FreqW    = 42;
  localparam int FracW    = 16;
  localparam int ScaleW   = 26;
  localparam int TbW      = 4;
  localparam int DivW     = FreqW;  // divider dividend / quotient width
  localparam int DivisorW = PosW;   // divider divisor width
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 8;
  localparam int TdataOW  = 56;   // 55 payload bits padded to whole bytes

  localparam logic [PosW-1:0]     PosMax      = '1;
  localparam logic [TbW-1:0]      TbPassThru  = 4'd15;
  localparam logic [CountW-1:0]   MinCount    = 4'd3;
  localparam logic [SampleW-1:0]  TriggerRst  = 8'd128;

  localparam logic [CfgAddrW-1:0] RegTriggerLevel  = 2'd0;
  localparam logic [CfgAddrW-1:0] RegTimebaseIndex = 2'd1;

  typedef struct packed {
    logic in_ready;   // sample transfers allowed
    logic div_start;  // one-cycle start of the shared divider
    logic div_freq;   // 0: period division, 1: frequency division
    logic load_out;   // move the finished result into the output register
  } cpfe_cmd_t;

  typedef struct packed {
    logic frame_end;    // sample with tlast transferred this cycle
    logic job_valid;    // latched frame has at least three crossings
    logic passthrough;  // timebase index selects the period itself
    logic div_done;     // divider quotient ready
    logic out_full;     // output register still holds a result
  } cpfe_status_t;

  function automatic logic [ScaleW-1:0] cpfe_scale(input logic [TbW-1:0] idx);
    logic [ScaleW-1:0] s;
    case (idx)
      4'd0:    s = 26'd1250;
      4'd1:    s = 26'd2500;
      4'd2:    s = 26'd5000;
      4'd3:    s = 26'd12500;
      4'd4:    s = 26'd25000;
      4'd5:    s = 26'd50000;
      4'd6:    s = 26'd125000;
      4'd7:    s = 26'd250000;
      4'd8:    s = 26'd500000;
      4'd9:    s = 26'd1250000;
      4'd10:   s = 26'd2500000;
      4'd11:   s = 26'd5000000;
      4'd12:   s = 26'd12500000;
      4'd13:   s = 26'd25000000;
      default: s = 26'd50000000;
    endcase
    return s;
  endfunction

endpackage

@@ design/cpfe_div.sv @@
`timescale 1ns / 1ps
// cpfe_div: radix-2 restoring divider, one quotient bit per cycle.
// Depends on cpfe_pkg for the operand widths.
module cpfe_div
  import cpfe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DivW-1:0]     dividend_i,
  input  logic [DivisorW-1:0] divisor_i,
  output logic [DivW-1:0]     quotient_o,
  output logic                done_o
);

  localparam int CntW = $clog2(DivW);
  localparam logic [CntW-1:0] LastStep = CntW'(DivW - 1);

  logic                busy_q, done_q;
  logic [CntW-1:0]     step_q;
  logic [DivW-1:0]     quo_q, quo_d;
  logic [DivisorW-1:0] rem_q, rem_d, dsr_q;
  logic [DivisorW:0]   trial;
  logic                fits;

  // divisor of zero gives all ones, like a saturated result
  always_comb begin
    trial = {rem_q, quo_q[DivW-1]};
    fits  = trial >= {1'b0, dsr_q};
    rem_d = fits ? DivisorW'(trial - {1'b0, dsr_q}) : trial[DivisorW-1:0];
    quo_d = {quo_q[DivW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

@@ design/cpfe_datapath.sv @@
`timescale 1ns / 1ps
// cpfe_datapath: crossing detection, frame job latch, divider operands and output register.
// Depends on cpfe_pkg and cpfe_div.
module cpfe_datapath
  import cpfe_pkg::*;
#(
  parameter int WINDOW_LENGTH = 500,
  parameter int SKIP_SAMPLES  = 5,
  parameter int MAX_CROSSINGS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  input  logic [SampleW-1:0]  s_axis_tdata,
  input  logic                s_axis_tlast,
  input  logic                m_axis_tready,
  output logic                m_axis_tvalid,
  output logic [TdataOW-1:0]  m_axis_tdata,
  output logic                m_axis_tuser,
  input  cpfe_cmd_t           cmd_i,
  output cpfe_status_t        status_o
);

  localparam logic [PosW:0]     WinLo  = (PosW+1)'(SKIP_SAMPLES + 1);
  localparam logic [PosW:0]     WinHi  = (PosW+1)'(SKIP_SAMPLES + 1 + WINDOW_LENGTH);
  localparam logic [PosW-1:0]   PosOfs = PosW'(SKIP_SAMPLES + 1);
  localparam logic [CountW-1:0] MaxCnt = CountW'(MAX_CROSSINGS);

  logic [SampleW-1:0] trig_q;
  logic [TbW-1:0]     tb_q;

  logic [SampleW-1:0] prev_q;
  logic [PosW-1:0]    pos_q, second_q, latest_q, second_d, latest_d, win_pos;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic               take, in_win, hit;

  logic [CountW-1:0]  job_cnt_q;
  logic [PosW-1:0]    job_dist_q, period_q;
  logic [FreqW-1:0]   freq_q;

  logic [DivW-1:0]     div_dividend, div_quo;
  logic [DivisorW-1:0] div_divisor;
  logic                div_done;

  logic                job_valid;
  logic [FreqW-1:0]    out_freq;
  logic [PeriodW-1:0]  out_period;
  logic                out_valid_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q <= TriggerRst;
      tb_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegTriggerLevel:  trig_q <= cfg_wdata_i;
        RegTimebaseIndex: tb_q   <= cfg_wdata_i[TbW-1:0];
        default: ;
      endcase
    end
  end

  // rising crossing detection; the tlast sample takes part too
  always_comb begin
    take     = s_axis_tvalid && cmd_i.in_ready;
    in_win   = ({1'b0, pos_q} >= WinLo) && ({1'b0, pos_q} < WinHi);
    hit      = in_win && (s_axis_tdata >= trig_q) && (prev_q < trig_q) && (cnt_q < MaxCnt);
    win_pos  = pos_q - PosOfs;
    cnt_d    = cnt_q + CountW'(hit);
    second_d = (hit && cnt_q == CountW'(1)) ? win_pos : second_q;
    latest_d = hit ? win_pos : latest_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      pos_q    <= '0;
      cnt_q    <= '0;
      second_q <= '0;
      latest_q <= '0;
    end else if (take) begin
      if (s_axis_tlast) begin
        prev_q   <= '0;
        pos_q    <= '0;
        cnt_q    <= '0;
        second_q <= '0;
        latest_q <= '0;
      end else begin
        prev_q   <= s_axis_tdata;
        pos_q    <= (pos_q == PosMax) ? pos_q : pos_q + 1'b1;
        cnt_q    <= cnt_d;
        second_q <= second_d;
        latest_q <= latest_d;
      end
    end
  end

  // frame summary handed to the division phase
  always_ff @(posedge clk_i) begin
    if (take && s_axis_tlast) begin
      job_cnt_q  <= cnt_d;
      job_dist_q <= latest_d - second_d;
    end
  end

  assign job_valid = job_cnt_q >= MinCount;

  always_comb begin
    if (cmd_i.div_freq) begin
      div_dividend = {cpfe_scale(tb_q), {FracW{1'b0}}};
      div_divisor  = period_q;
    end else begin
      div_dividend = DivW'(job_dist_q);
      div_divisor  = DivisorW'(job_cnt_q - CountW'(2));
    end
  end

  cpfe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i) begin
    if (div_done && !cmd_i.div_freq) period_q <= div_quo[PosW-1:0];
    if (div_done &&  cmd_i.div_freq) freq_q   <= div_quo;
  end

  always_comb begin
    out_freq   = '0;
    out_period = '0;
    if (job_valid) begin
      out_period = period_q[PeriodW-1:0];
      out_freq   = (tb_q == TbPassThru) ? {{(FreqW-PosW-FracW){1'b0}}, period_q, {FracW{1'b0}}}
                                         : freq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      m_axis_tdata <= {1'b0, job_cnt_q, out_period, out_freq};
      m_axis_tuser <= job_valid;
    end
  end

  assign m_axis_tvalid = out_valid_q;

  assign status_o = '{
    frame_end:   take && s_axis_tlast,
    job_valid:   job_valid,
    passthrough: tb_q == TbPassThru,
    div_done:    div_done,
    out_full:    out_valid_q
  };

endmodule

@@ design/cpfe_ctrl.sv @@
`timescale 1ns / 1ps
// cpfe_ctrl: frame sequencer, collect samples, run period and frequency divisions,
// hand the result to the output register. Depends on cpfe_pkg.
module cpfe_ctrl
  import cpfe_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cpfe_status_t status_i,
  output cpfe_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    Collect,
    Check,
    WaitPeriod,
    WaitFreq,
    Finish
  } state_e;

  state_e state_q;
  logic   in_ready_q, div_start_q, div_freq_q, load_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Collect;
      in_ready_q  <= 1'b1;
      div_start_q <= 1'b0;
      div_freq_q  <= 1'b0;
      load_out_q  <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      load_out_q  <= 1'b0;
      case (state_q)
        Collect: begin
          if (status_i.frame_end) begin
            in_ready_q <= 1'b0;
            state_q    <= Check;
          end
        end
        Check: begin
          if (status_i.job_valid) begin
            div_start_q <= 1'b1;
            div_freq_q  <= 1'b0;
            state_q     <= WaitPeriod;
          end else begin
            state_q <= Finish;
          end
        end
        WaitPeriod: begin
          if (status_i.div_done) begin
            if (status_i.passthrough) begin
              state_q <= Finish;
            end else begin
              div_start_q <= 1'b1;
              div_freq_q  <= 1'b1;
              state_q     <= WaitFreq;
            end
          end
        end
        WaitFreq: begin
          if (status_i.div_done) state_q <= Finish;
        end
        Finish: begin
          // wait for the previous result to leave the output register
          if (!status_i.out_full) begin
            load_out_q <= 1'b1;
            in_ready_q <= 1'b1;
            state_q    <= Collect;
          end
        end
        default: state_q <= Collect;
      endcase
    end
  end

  assign cmd_o = '{
    in_ready:  in_ready_q,
    div_start: div_start_q,
    div_freq:  div_freq_q,
    load_out:  load_out_q
  };

endmodule

@@ design/crossing_period_frequency_estimator.sv @@
`timescale 1ns / 1ps
// Crossing period frequency estimator, top level. Depends on cpfe_pkg, cpfe_ctrl, cpfe_datapath.
// Throughput: one sample per cycle within a frame; after the tlast transfer input stalls
// while the shared radix-2 divider runs for the period and then the frequency; with
// timebase index 15 there is no frequency division, with fewer than three crossings no
// division at all. Input reopens in the cycle before the result turns valid.
// Reset (async, low): frame state cleared, trigger level 128, timebase index 0, no output.
module crossing_period_frequency_estimator
  import cpfe_pkg::*;
#(
  parameter int WINDOW_LENGTH = 500,
  parameter int SKIP_SAMPLES  = 5,
  parameter int MAX_CROSSINGS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [SampleW-1:0]  s_axis_tdata,   // [7:0] sample
  input  logic                s_axis_tlast,   // last_sample
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [TdataOW-1:0]  m_axis_tdata,   // [41:0] frequency, [50:42] period_samples,
                                              // [54:51] crossing_count, [55] zero
  output logic                m_axis_tuser    // [0] valid_res
);

  cpfe_cmd_t    cmd;
  cpfe_status_t status;

  cpfe_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  cpfe_datapath #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .SKIP_SAMPLES  (SKIP_SAMPLES),
    .MAX_CROSSINGS (MAX_CROSSINGS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cmd_i         (cmd),
    .status_o      (status)
  );

  assign s_axis_tready = cmd.in_ready;

  // an invalid result carries zero frequency and period
  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[50:0] == '0)
    else $error("invalid result with nonzero frequency or period");

  // valid flag agrees with the reported crossing count
  a_valid_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[54:51] >= MinCount) == m_axis_tuser)
    else $error("valid_res disagrees with crossing count");

  a_count_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[54:51] <= CountW'(MAX_CROSSINGS))
    else $error("crossing count above cap");

  // no sample is taken while a division is being started
  a_no_take_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !s_axis_tready)
    else $error("input ready during division");

endmodule

@@ verif/crossing_estimate_checker.sv @@
`timescale 1ns / 1ps
// crossing_estimate_checker: watches the config port, the sample stream and the estimate
// stream of the estimator, predicts every frame's estimate and compares it. Uses cpfe_pkg.
module crossing_estimate_checker
  import cpfe_pkg::*;
#(
  parameter int WindowLen = 500,
  parameter int SkipLen   = 5,
  parameter int MaxCross  = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [SampleW-1:0]  in_data_i,
  input  logic                in_last_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [TdataOW-1:0]  out_data_i,
  input  logic                out_user_i,
  output int                  mismatches_o,
  output int                  pending_o,
  output int                  checked_o,
  output int                  valid_seen_o
);

  localparam int PeriodLsb = FreqW;
  localparam int CountLsb  = FreqW + PeriodW;

  typedef struct packed {
    logic [FreqW-1:0]   freq;
    logic [PeriodW-1:0] period;
    logic [CountW-1:0]  count;
    logic               ok;
  } estimate_t;

  // register copies
  logic [SampleW-1:0] trig_q;
  logic [TbW-1:0]     tb_q;

  // frame tracking
  logic [SampleW-1:0] prev_q;
  logic [PosW-1:0]    pos_q;
  logic [CountW-1:0]  found_q;
  logic [PeriodW-1:0] second_q;
  logic [PeriodW-1:0] latest_q;

  estimate_t pending_estimates[$];
  int mismatches;
  int checked;
  int valid_seen;

  function automatic logic [63:0] timebase_scale(input logic [TbW-1:0] idx);
    logic [63:0] v;
    case (idx)
      4'd0:    v = 64'd1250;
      4'd1:    v = 64'd2500;
      4'd2:    v = 64'd5000;
      4'd3:    v = 64'd12500;
      4'd4:    v = 64'd25000;
      4'd5:    v = 64'd50000;
      4'd6:    v = 64'd125000;
      4'd7:    v = 64'd250000;
      4'd8:    v = 64'd500000;
      4'd9:    v = 64'd1250000;
      4'd10:   v = 64'd2500000;
      4'd11:   v = 64'd5000000;
      4'd12:   v = 64'd12500000;
      4'd13:   v = 64'd25000000;
      default: v = 64'd50000000;
    endcase
    return v;
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    $display("%0t ns: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic clear_frame();
    prev_q   = '0;
    pos_q    = '0;
    found_q  = '0;
    second_q = '0;
    latest_q = '0;
  endtask

  task automatic track_crossing(input logic [SampleW-1:0] s, input logic last);
    estimate_t   est;
    logic [63:0] period;
    logic [63:0] freq;
    if (pos_q >= SkipLen + 1 && pos_q < SkipLen + 1 + WindowLen) begin
      if (s >= trig_q && prev_q < trig_q && found_q < MaxCross) begin
        if (found_q == 1) second_q = PeriodW'(pos_q - SkipLen - 1);
        latest_q = PeriodW'(pos_q - SkipLen - 1);
        found_q++;
      end
    end
    prev_q = s;
    if (pos_q != PosMax) pos_q++;
    if (last) begin
      period = '0;
      freq   = '0;
      if (found_q >= MinCount) begin
        period = (64'(latest_q) - 64'(second_q)) / (64'(found_q) - 64'd2);
        if (tb_q == TbPassThru) freq = period << FracW;
        else if (period == 0) freq = '1;  // cannot happen with distinct crossings
        else freq = (timebase_scale(tb_q) << FracW) / period;
      end
      est.freq   = freq[FreqW-1:0];
      est.period = period[PeriodW-1:0];
      est.count  = found_q;
      est.ok     = (found_q >= MinCount);
      pending_estimates.push_back(est);
      clear_frame();
    end
  endtask

  task automatic check_estimate();
    estimate_t want;
    if (pending_estimates.size() == 0) begin
      flag_mismatch("estimate with none outstanding, frequency",
                    64'(out_data_i[FreqW-1:0]), 64'd0);
    end else begin
      want = pending_estimates.pop_front();
      checked++;
      if (want.ok) valid_seen++;
      if (out_data_i[FreqW-1:0] != want.freq)
        flag_mismatch("frequency", 64'(out_data_i[FreqW-1:0]), 64'(want.freq));
      if (out_data_i[PeriodLsb +: PeriodW] != want.period)
        flag_mismatch("period_samples", 64'(out_data_i[PeriodLsb +: PeriodW]),
                      64'(want.period));
      if (out_data_i[CountLsb +: CountW] != want.count)
        flag_mismatch("crossing_count", 64'(out_data_i[CountLsb +: CountW]),
                      64'(want.count));
      if (out_user_i != want.ok)
        flag_mismatch("valid_res", 64'(out_user_i), 64'(want.ok));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q = TriggerRst;
      tb_q   = '0;
      clear_frame();
      pending_estimates.delete();
      mismatches = 0;
      checked    = 0;
      valid_seen = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == RegTriggerLevel) trig_q = cfg_wdata_i;
        else if (cfg_addr_i == RegTimebaseIndex) tb_q = cfg_wdata_i[TbW-1:0];
      end
      if (in_valid_i && in_ready_i) track_crossing(in_data_i, in_last_i);
      if (out_valid_i && out_ready_i) check_estimate();
    end
    mismatches_o <= mismatches;
    pending_o    <= pending_estimates.size();
    checked_o    <= checked;
    valid_seen_o <= valid_seen;
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// testbench: drives frames of samples and config writes into the crossing period frequency
// estimator and gives the verdict. Depends on cpfe_pkg and crossing_estimate_checker.
module testbench;
  import cpfe_pkg::*;

  localparam int CycleLimit     = 400000;
  localparam int RxHoldCycles   = 400;
  localparam int HoldPhase      = 6;
  localparam int NoIdlePhase    = 10;
  localparam int QuietFromPhase = 14;
  localparam int Phases         = 16;
  localparam int FramesPerPhase = 3;
  localparam int SettleCycles   = 8;
  localparam int EndCycles      = 120;

  // indexes with no register behind them
  localparam logic [CfgAddrW-1:0] RegSpare2 = 2'd2;
  localparam logic [CfgAddrW-1:0] RegSpare3 = 2'd3;

  typedef enum int {FrameNoise, FrameFlat, FrameWave} frame_kind_e;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [SampleW-1:0]  s_axis_tdata;   // [7:0] sample
  logic                s_axis_tlast;   // last_sample
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [TdataOW-1:0]  m_axis_tdata;   // [41:0] frequency, [50:42] period_samples,
                                       // [54:51] crossing_count, [55] zero
  logic                m_axis_tuser;   // [0] valid_res

  int mismatches;
  int pending;
  int checked;
  int valid_seen;

  int                 phase_no;
  logic               idle_on;
  logic               rx_hold_done;
  int                 samples_sent;
  int                 frames_sent;
  logic [SampleW-1:0] trig_now;
  int                 cycles;

  crossing_period_frequency_estimator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  crossing_estimate_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_user_i   (m_axis_tuser),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .valid_seen_o (valid_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: random stalls, one long hold-off during the hold phase
  initial begin
    int hold_cnt;
    m_axis_tready = 1'b0;
    rx_hold_done  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!rx_hold_done && phase_no == HoldPhase) begin
        rx_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        for (hold_cnt = 1; hold_cnt < RxHoldCycles; hold_cnt++) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(input logic [SampleW-1:0] s, input logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    samples_sent++;
    if (last) frames_sent++;
  endtask

  // mostly square-ish waves around the trigger with random levels, some noise and flat frames
  task automatic send_frame(input int len, input int per_max);
    frame_kind_e        kind;
    int                 pick;
    int                 per;
    int                 hi_len;
    int                 ofs;
    int                 j;
    logic [SampleW-1:0] lvl;
    logic [SampleW-1:0] s;
    pick   = $urandom_range(0, 9);
    kind   = (pick == 0) ? FrameNoise : (pick == 1) ? FrameFlat : FrameWave;
    per    = $urandom_range(2, per_max);
    hi_len = $urandom_range(1, per - 1);
    ofs    = $urandom_range(0, per - 1);
    lvl    = SampleW'($urandom_range(0, 255));
    for (j = 0; j < len; j++) begin
      case (kind)
        FrameNoise: s = SampleW'($urandom_range(0, 255));
        FrameFlat:  s = lvl;
        default: begin
          if ((j + ofs) % per < hi_len) s = SampleW'($urandom_range(trig_now, 255));
          else if (trig_now == 0) s = '0;
          else s = SampleW'($urandom_range(0, trig_now - 1));
        end
      endcase
      send_sample(s, j == len - 1);
    end
  endtask

  // sender pause until every outstanding estimate has come back
  task automatic drain(input int settle);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  initial begin
    int          ph;
    int          f;
    int          j;
    logic [3:0]  hi_nib;
    logic [CfgDataW-1:0] junk;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    phase_no      = -1;
    idle_on       = 1'b1;
    samples_sent  = 0;
    frames_sent   = 0;
    trig_now      = TriggerRst;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset register values
    send_sample(8'hFF, 1'b1);                 // one-sample frame, nothing found
    for (j = 0; j < 12; j++)                  // three crossings, the last on the tlast sample
      send_sample((j % 2) ? 8'hFF : 8'h00, j == 11);
    for (j = 0; j < 6; j++) send_sample(8'h00, 1'b0);
    send_sample(8'd128, 1'b0);                // exactly at the level counts
    send_sample(8'd127, 1'b0);
    send_sample(8'd128, 1'b1);                // two crossings only
    drain(SettleCycles);

    for (ph = 0; ph < Phases; ph++) begin
      phase_no <= ph;
      idle_on  <= (ph < QuietFromPhase) && (ph != NoIdlePhase);
      case (ph)
        0:       trig_now = 8'd0;
        1:       trig_now = 8'd255;
        2:       trig_now = 8'd1;
        3:       trig_now = 8'd254;
        default: trig_now = SampleW'($urandom_range(0, 255));
      endcase
      if (ph == 0) begin
        junk = CfgDataW'($urandom_range(0, 255));
        write_reg(RegSpare2, junk);
        junk = CfgDataW'($urandom_range(0, 255));
        write_reg(RegSpare3, junk);
      end
      hi_nib = 4'($urandom_range(0, 15));     // upper bits must be dropped
      write_reg(RegTriggerLevel, trig_now);
      write_reg(RegTimebaseIndex, {hi_nib, ph[3:0]});
      for (f = 0; f < FramesPerPhase; f++)
        send_frame($urandom_range(1, 20), 5);
      drain(SettleCycles);
    end

    drain(EndCycles);
    $display("run: %0d samples in %0d frames, %0d estimates checked, %0d with a period",
             samples_sent, frames_sent, checked, valid_seen);
    $display("run: trigger extremes, all 16 timebases, unused indexes, long output stall");
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ crossing_period_frequency_estimator.f @@
design/cpfe_pkg.sv
design/cpfe_div.sv
design/cpfe_datapath.sv
design/cpfe_ctrl.sv
design/crossing_period_frequency_estimator.sv
verif/crossing_estimate_checker.sv
verif/testbench.sv
